FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, masked while rst_n is low
`define GWM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gwm checker: property violated");

// concurrent check on clk that also holds during reset
`define GWM_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("gwm checker: property violated");

`endif

FILE: rtl/core/gwm_pkg.sv
`timescale 1ns / 1ps

package gwm_pkg;

  localparam int PATTERN_LEN = 32;
  localparam int LEN_W       = $clog2(PATTERN_LEN + 1);
  localparam int CHAR_W      = 8;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int CHARS_PER_REG = CFG_W / CHAR_W;

  localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
  localparam logic [CHAR_W-1:0] ANY_CHAR  = 8'h3F;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_0_7   = 3'd0,
    CFG_PAT_8_15  = 3'd1,
    CFG_PAT_16_23 = 3'd2,
    CFG_PAT_24_31 = 3'd3,
    CFG_PAT_LEN   = 3'd4,
    CFG_MATCH_ALL = 3'd5
  } cfg_idx_t;

  // per-beat selection of the source set
  typedef struct packed {
    logic first;
    logic empty;
  } sel_t;

  // signals handed from one cell to the next
  typedef struct packed {
    logic adv;    // previous position consumed the character
    logic clo;    // previous position is an active star
    logic start;  // start-set bit reaching this position
  } link_t;

endpackage

FILE: rtl/core/gwm_cell.sv
`timescale 1ns / 1ps

module gwm_cell import gwm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CHAR_W-1:0] pat_char,
  input  logic              in_use,
  input  logic [CHAR_W-1:0] name_char,
  input  sel_t              sel,
  input  logic              load,
  input  link_t             link_in,
  output link_t             link_out,
  output logic              act_nxt
);

  logic act_r;
  logic start_r;
  logic is_star;
  logic hit;
  logic src;
  logic fin;

  assign is_star = (pat_char == STAR_CHAR);
  assign hit     = (pat_char == ANY_CHAR) || (pat_char == name_char);
  assign src     = sel.first ? start_r : act_r;

  // star keeps itself; closure carry ripples along runs of stars
  assign fin = link_in.adv | (src & is_star & in_use) | link_in.clo;

  assign link_out.adv   = src & in_use & ~is_star & hit;
  assign link_out.clo   = fin & is_star & in_use;
  assign link_out.start = link_in.start & is_star & in_use;

  assign act_nxt = sel.empty ? start_r : fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= 1'b0;
      start_r <= 1'b0;
    end else begin
      start_r <= link_in.start;
      if (load) begin
        act_r <= act_nxt;
      end
    end
  end

endmodule

FILE: rtl/core/gwm_row.sv
`timescale 1ns / 1ps

module gwm_row import gwm_pkg::*; (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [PATTERN_LEN-1:0][CHAR_W-1:0]  pat,
  input  logic [LEN_W-1:0]                    len,
  input  logic [CHAR_W-1:0]                   name_char,
  input  sel_t                                sel,
  input  logic                                load,
  output logic [PATTERN_LEN:0]                act_nxt
);

  link_t link [PATTERN_LEN+1];
  logic  end_start_r;

  assign link[0] = '{adv: 1'b0, clo: 1'b0, start: 1'b1};

  for (genvar k = 0; k < PATTERN_LEN; k++) begin : g_cell
    gwm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .pat_char  (pat[k]),
      .in_use    (len > LEN_W'(k)),
      .name_char (name_char),
      .sel       (sel),
      .load      (load),
      .link_in   (link[k]),
      .link_out  (link[k+1]),
      .act_nxt   (act_nxt[k])
    );
  end

  // position after the last pattern character, never a source so not stored
  assign act_nxt[PATTERN_LEN] = sel.empty ? end_start_r
                                          : (link[PATTERN_LEN].adv | link[PATTERN_LEN].clo);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_start_r <= 1'b0;
    end else begin
      end_start_r <= link[PATTERN_LEN].start;
    end
  end

endmodule

FILE: rtl/core/glob_wildcard_matcher.sv
`timescale 1ns / 1ps

// Glob matcher: a name arrives one character per input beat (in_tdata) and is
// matched against a pattern of up to 32 characters written through the cfg
// port, where '*' matches any run of characters and '?' any single character.
// in_tuser[0] marks the first character of a name, in_tuser[1] an empty name.
// Every input beat yields one output beat whose bit 0 tells whether the name
// so far matches the whole pattern (always 1 while match_all is set). The
// block takes one beat per cycle while the result stream is not stalled: a
// beat passes from the input register to the output register, and the row
// of 32 position cells updates the whole active set combinationally between
// the two, its star-closure carry rippling through all cells. Pattern writes
// do not apply to a beat accepted in the same cycle as the write, because
// the start set is registered inside the cells.

module glob_wildcard_matcher import gwm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] name_char
  input  logic [1:0]           in_tuser,   // [0] first_char, [1] empty_name
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [0] matched, [7:1] zero
  // configuration writes
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // configuration registers
  logic [PATTERN_LEN-1:0][CHAR_W-1:0] pat_r;
  logic [LEN_W-1:0]                   pat_len_r;
  logic                               match_all_r;
  logic [LEN_W-1:0]                   len_eff;

  // input stage
  logic              s1_valid_r;
  logic [CHAR_W-1:0] s1_char_r;
  sel_t              s1_sel_r;
  logic              s1_fire;

  // output register
  logic              out_valid_r;
  logic              matched_r;
  logic              matched_nxt;

  logic [PATTERN_LEN:0] act_nxt;

  // lengths beyond the row are clamped
  assign len_eff = (pat_len_r > LEN_W'(PATTERN_LEN)) ? LEN_W'(PATTERN_LEN) : pat_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r       <= '0;
      pat_len_r   <= '0;
      match_all_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PAT_0_7: begin
          for (int b = 0; b < CHARS_PER_REG; b++) begin
            pat_r[b] <= cfg_wdata[b*CHAR_W +: CHAR_W];
          end
        end
        CFG_PAT_8_15: begin
          for (int b = 0; b < CHARS_PER_REG; b++) begin
            pat_r[CHARS_PER_REG + b] <= cfg_wdata[b*CHAR_W +: CHAR_W];
          end
        end
        CFG_PAT_16_23: begin
          for (int b = 0; b < CHARS_PER_REG; b++) begin
            pat_r[2*CHARS_PER_REG + b] <= cfg_wdata[b*CHAR_W +: CHAR_W];
          end
        end
        CFG_PAT_24_31: begin
          for (int b = 0; b < CHARS_PER_REG; b++) begin
            pat_r[3*CHARS_PER_REG + b] <= cfg_wdata[b*CHAR_W +: CHAR_W];
          end
        end
        CFG_PAT_LEN:   pat_len_r   <= cfg_wdata[LEN_W-1:0];
        CFG_MATCH_ALL: match_all_r <= cfg_wdata[0];
        default: ;  // writes to unused indexes are dropped
      endcase
    end
  end

  // stage 1 advances when the output register is free or being drained
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_char_r      <= in_tdata;
      s1_sel_r.first <= in_tuser[0];
      s1_sel_r.empty <= in_tuser[1];
    end
  end

  // row of position cells holding the active set
  gwm_row u_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .pat       (pat_r),
    .len       (len_eff),
    .name_char (s1_char_r),
    .sel       (s1_sel_r),
    .load      (s1_fire),
    .act_nxt   (act_nxt)
  );

  // whole pattern consumed when the position at the pattern end is active
  assign matched_nxt = match_all_r | act_nxt[len_eff];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      matched_r <= matched_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, matched_r};

endmodule

FILE: rtl/core/gwm_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module gwm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // a stalled result holds its value
  `GWM_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))

  // reset empties the result side
  `GWM_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_tvalid)

  // every accepted beat is followed by a valid result on the output
  `GWM_ASSERT(a_result_due, in_tvalid && in_tready |=> ##1 out_tvalid)

  // input only backs up behind a stalled result
  `GWM_ASSERT(a_stall_cause, !in_tready |-> out_tvalid && !out_tready)

  // padding bits above matched stay zero
  `GWM_ASSERT(a_pad_zero, out_tvalid |-> out_tdata[7:1] == 7'b0)

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (.*);

FILE: test/glob_wildcard_matcher_tb.sv
`timescale 1ns / 1ps

module glob_wildcard_matcher_tb;
  import gwm_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_BEATS = 1550;

  // one name character beat as it travels on the input stream
  typedef struct packed {
    logic       empty;
    logic       first;
    logic [7:0] ch;
  } name_beat_t;

  // how often a side of the stream holds off
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_RANDOM,
    IDLE_SPARSE
  } idle_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = '0;   // [7:0] name_char
  logic [1:0]           in_tuser = '0;   // [0] first_char, [1] empty_name
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;       // [0] matched, [7:1] zero
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_PAT_0_7;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  glob_wildcard_matcher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // matcher model: its own copy of the pattern registers and the active set
  // ---------------------------------------------------------------------------
  logic [63:0] pat_words [4];
  logic [5:0]  pat_len_q;
  logic        match_all_q;
  logic [32:0] active_set;     // bit k: first k pattern chars fit the name so far

  // pattern image that the stimulus builds before programming it
  logic [7:0]  pat_img [32];

  function automatic logic [7:0] pat_char(int k);
    return pat_words[k / 8][(k % 8) * 8 +: 8];
  endfunction

  // lengths above the cell count behave as a full pattern
  function automatic int used_len();
    return (pat_len_q > 6'd32) ? 32 : int'(pat_len_q);
  endfunction

  // an active star also enables the position right after it
  function automatic logic [32:0] close_over_stars(logic [32:0] s, int n);
    for (int k = 0; k < n; k++)
      if (s[k] && pat_char(k) == STAR_CHAR) s[k + 1] = 1'b1;
    return s;
  endfunction

  function automatic logic [32:0] consume_char(logic [32:0] s, logic [7:0] c, int n);
    logic [32:0] nxt;
    nxt = '0;
    for (int k = 0; k < n; k++) begin
      if (s[k]) begin
        if (pat_char(k) == STAR_CHAR) nxt[k] = 1'b1;
        else if (pat_char(k) == ANY_CHAR || pat_char(k) == c) nxt[k + 1] = 1'b1;
      end
    end
    return close_over_stars(nxt, n);
  endfunction

  // advances the active set by one beat and tells whether the name matches
  function automatic logic predict_match(name_beat_t b);
    int          n;
    logic [32:0] start_set;
    n = used_len();
    start_set = close_over_stars(33'd1, n);
    // empty name wins over first_char; a bare continuation advances the old set
    if (b.empty) active_set = start_set;
    else if (b.first) active_set = consume_char(start_set, b.ch, n);
    else active_set = consume_char(active_set, b.ch, n);
    return match_all_q ? 1'b1 : active_set[n];
  endfunction

  // ---------------------------------------------------------------------------
  // shared state between the stimulus, the driver and the checker
  // ---------------------------------------------------------------------------
  name_beat_t  pending_chars [$];
  logic [7:0]  expected_matches [$];
  idle_mode_t  send_idle = IDLE_NONE;
  idle_mode_t  recv_idle = IDLE_NONE;
  int unsigned in_taken = 0, in_seen = 0;
  int unsigned out_taken = 0, out_seen = 0;
  int unsigned send_wait = 0, recv_wait = 0;
  int unsigned errors = 0;
  int unsigned matches_seen = 0;
  int unsigned beats_queued = 0;
  int unsigned settings_used = 0;
  int unsigned cycle_count = 0;

  function automatic int unsigned draw_wait(idle_mode_t mode);
    case (mode)
      IDLE_NONE:   return 0;
      IDLE_RANDOM: return $urandom_range(0, 16);
      default:     return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one name beat at a time, a random hold-off after each
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_names
    name_beat_t nb;
    logic       nv;
    if (rst_n) begin
      nv = in_tvalid;
      // the beat went out at the last rising edge
      if (in_taken != in_seen) begin
        in_seen = in_taken;
        nv = 1'b0;
      end
      if (!nv) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_chars.size() > 0) begin
          nb = pending_chars.pop_front();
          in_tdata <= nb.ch;
          in_tuser <= {nb.empty, nb.first};
          nv = 1'b1;
          send_wait = draw_wait(send_idle);
        end
      end
      in_tvalid <= nv;
    end
  end

  // result side backpressure: a fresh stall length after every result beat
  always @(negedge clk) begin : pace_results
    if (rst_n) begin
      if (out_taken != out_seen) begin
        out_seen = out_taken;
        recv_wait = draw_wait(recv_idle);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checker: predict at input acceptance, compare in order at output acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    logic [7:0] want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_matches.push_back({7'd0, predict_match(name_beat_t'({in_tuser, in_tdata}))});
        in_taken++;
      end
      if (out_tvalid && out_tready) begin
        out_taken++;
        if (out_tdata[0] === 1'b1) matches_seen++;
        if (expected_matches.size() == 0) begin
          errors++;
          $display("%0t: result beat %h arrived, expected none", $time, out_tdata);
        end else begin
          want = expected_matches.pop_front();
          if (out_tdata !== want) begin
            errors++;
            $display("%0t: matched mismatch, expected %h, actual %h", $time, want, out_tdata);
          end
        end
      end
    end
  end

  // hard stop in case the stream stalls for good
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_matches.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_beat(logic [7:0] c, logic first, logic empty);
    name_beat_t b;
    b.ch = c;
    b.first = first;
    b.empty = empty;
    pending_chars.push_back(b);
    beats_queued++;
  endtask

  // a zero-length name goes out as a single empty-name beat
  task automatic push_name(logic [7:0] nm [$]);
    if (nm.size() == 0) begin
      push_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    end else begin
      foreach (nm[i]) push_beat(nm[i], i == 0, 1'b0);
    end
  endtask

  task automatic push_str(string s);
    logic [7:0] nm [$];
    for (int i = 0; i < s.len(); i++) nm.push_back(s[i]);
    push_name(nm);
  endtask

  function automatic logic [7:0] random_name_char();
    case ($urandom_range(0, 3))
      0:       return "a";
      1:       return "b";
      2:       return "c";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] random_pattern_char();
    case ($urandom_range(0, 9))
      0, 1:    return STAR_CHAR;
      2:       return ANY_CHAR;
      3, 4:    return "a";
      5:       return "b";
      6:       return "c";
      7:       return 8'h00;
      8:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // pattern text in the low positions, noise in the unused ones
  task automatic fill_pattern(string s);
    for (int k = 0; k < 32; k++)
      pat_img[k] = (k < s.len()) ? s[k] : 8'($urandom_range(0, 255));
  endtask

  function automatic logic [63:0] pack_chars(int base);
    logic [63:0] w;
    for (int b = 0; b < 8; b++) w[b * 8 +: 8] = pat_img[base + b];
    return w;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [63:0] v);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    case (idx)
      CFG_PAT_0_7:   pat_words[0] = v;
      CFG_PAT_8_15:  pat_words[1] = v;
      CFG_PAT_16_23: pat_words[2] = v;
      CFG_PAT_24_31: pat_words[3] = v;
      CFG_PAT_LEN:   pat_len_q = v[5:0];
      CFG_MATCH_ALL: match_all_q = v[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic program_pattern(logic [5:0] len_val, logic all);
    write_reg(CFG_PAT_0_7, pack_chars(0));
    write_reg(CFG_PAT_8_15, pack_chars(8));
    write_reg(CFG_PAT_16_23, pack_chars(16));
    write_reg(CFG_PAT_24_31, pack_chars(24));
    write_reg(CFG_PAT_LEN, {58'd0, len_val});
    write_reg(CFG_MATCH_ALL, {63'd0, all});
    settings_used++;
    // start set is registered in the cells, give it time to settle
    repeat (2) @(negedge clk);
  endtask

  // hold the sender until the stream is empty and the pipe has drained
  task automatic settle_stream();
    while (pending_chars.size() > 0 || in_tvalid || expected_matches.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // builds a name that fits the programmed pattern, optionally spoiled by one edit
  task automatic push_pattern_name(bit spoil);
    logic [7:0] nm [$];
    int         pos;
    for (int k = 0; k < used_len(); k++) begin
      if (pat_img[k] == STAR_CHAR) begin
        repeat ($urandom_range(0, 3)) nm.push_back(random_name_char());
      end else if (pat_img[k] == ANY_CHAR) begin
        nm.push_back(8'($urandom_range(0, 255)));
      end else begin
        nm.push_back(pat_img[k]);
      end
    end
    if (spoil) begin
      pos = (nm.size() > 0) ? $urandom_range(0, nm.size() - 1) : 0;
      case ($urandom_range(0, 2))
        0: if (nm.size() > 0) nm[pos] = random_name_char();
        1: if (nm.size() > 0) nm.delete(pos);
        default: nm.insert(pos, random_name_char());
      endcase
    end
    push_name(nm);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    logic [7:0] nm [$];
    logic [5:0] len_val;
    int         pick;
    int         directed_beats;

    // model view of the register reset values
    for (int r = 0; r < 4; r++) pat_words[r] = '0;
    pat_len_q = '0;
    match_all_q = 1'b1;
    active_set = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle = IDLE_SPARSE;
    recv_idle = IDLE_SPARSE;

    // literal, star and any-char mixed; first beats continue from the empty set
    fill_pattern("a*?b");
    program_pattern(6'd4, 1'b0);
    push_beat("a", 1'b0, 1'b0);
    push_beat("b", 1'b0, 1'b0);
    push_str("axb");
    push_str("aXYb");
    push_str("ab");
    push_beat("z", 1'b1, 1'b1);            // empty name beats first_char
    nm = '{8'h61, 8'h00, 8'hFF, 8'h62};    // extreme byte values inside the name
    push_name(nm);
    settle_stream();

    // stars only: the empty name already matches
    fill_pattern("***");
    program_pattern(6'd3, 1'b0);
    push_str("");
    push_str("x");
    settle_stream();

    // empty pattern on all-zero registers: only the empty name matches
    foreach (pat_img[k]) pat_img[k] = 8'h00;
    program_pattern(6'd0, 1'b0);
    push_str("");
    push_str("a");
    settle_stream();

    // length register above the cell count, full row of stars
    foreach (pat_img[k]) pat_img[k] = STAR_CHAR;
    program_pattern(6'd63, 1'b0);
    push_str("");
    push_str("q");
    settle_stream();

    // all-ones pattern registers with match_all set, then cleared mid-name
    foreach (pat_img[k]) pat_img[k] = 8'hFF;
    program_pattern(6'd32, 1'b1);
    push_str("ab");
    push_str("");
    settle_stream();
    program_pattern(6'd32, 1'b0);
    push_beat(8'hFF, 1'b0, 1'b0);
    push_beat(8'hFF, 1'b0, 1'b0);
    settle_stream();

    directed_beats = beats_queued;

    // random phases: a fresh pattern each time, mostly names built to fit it
    while (beats_queued < directed_beats + RANDOM_BEATS) begin
      settle_stream();
      foreach (pat_img[k]) pat_img[k] = random_pattern_char();
      case ($urandom_range(0, 19))
        0:       len_val = 6'd0;
        1:       len_val = 6'd32;
        2:       len_val = 6'($urandom_range(33, 63));
        default: len_val = 6'($urandom_range(1, 10));
      endcase
      program_pattern(len_val, $urandom_range(0, 7) == 0);
      send_idle = idle_mode_t'($urandom_range(0, 2));
      recv_idle = idle_mode_t'($urandom_range(0, 2));
      repeat ($urandom_range(8, 20)) begin
        pick = $urandom_range(0, 19);
        if (pick < 10) begin
          push_pattern_name(1'b0);
        end else if (pick < 13) begin
          push_pattern_name(1'b1);
        end else if (pick < 16) begin
          nm.delete();
          repeat ($urandom_range(1, 10)) nm.push_back(random_name_char());
          push_name(nm);
        end else if (pick < 18) begin
          push_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end else begin
          // stray continuation beats with no name start in front
          repeat ($urandom_range(1, 3)) push_beat(random_name_char(), 1'b0, 1'b0);
        end
      end
    end

    settle_stream();
    repeat (8) @(posedge clk);

    $display("ran %0d name beats under %0d register settings", beats_queued, settings_used);
    $display("%0d of %0d results reported a match", matches_seen, out_taken);
    if (errors == 0 && expected_matches.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/gwm_pkg.sv
rtl/core/gwm_cell.sv
rtl/core/gwm_row.sv
rtl/core/glob_wildcard_matcher.sv
rtl/core/gwm_checker.sv
test/glob_wildcard_matcher_tb.sv
